@@ rtl/oafc_pkg.sv @@
//------------------------------------------------------------------------------
// oafc_pkg: shared types and constants for the overlay alpha fade controller
// Phase codes, fixed-point widths, register indexes and controller commands.
//------------------------------------------------------------------------------
`default_nettype none
package oafc_pkg;
  localparam int MaxSettlePasses = 10;
  localparam int FracBits        = 8;
  localparam int AccW            = 16 + FracBits;
  localparam int PassW           = $clog2(MaxSettlePasses + 1);

  localparam logic [3:0] PH_HIDDEN      = 4'd0;
  localparam logic [3:0] PH_IN_DELAY    = 4'd1;
  localparam logic [3:0] PH_FADING_IN   = 4'd2;
  localparam logic [3:0] PH_MAX         = 4'd3;
  localparam logic [3:0] PH_DIS_FADE    = 4'd4;
  localparam logic [3:0] PH_DISABLED    = 4'd5;
  localparam logic [3:0] PH_IDLE_FADE   = 4'd6;
  localparam logic [3:0] PH_INACTIVE    = 4'd7;
  localparam logic [3:0] PH_OUT_DELAY   = 4'd8;
  localparam logic [3:0] PH_FADING_OUT  = 4'd9;

  localparam logic [2:0] REG_MAX_ALPHA       = 3'd0;
  localparam logic [2:0] REG_INACTIVE_ALPHA  = 3'd1;
  localparam logic [2:0] REG_FADE_IN_DELAY   = 3'd2;
  localparam logic [2:0] REG_FADE_OUT_DELAY  = 3'd3;
  localparam logic [2:0] REG_IDLE_FADE_DELAY = 3'd4;
  localparam logic [2:0] REG_FADE_IN_RATE    = 3'd5;
  localparam logic [2:0] REG_FADE_OUT_RATE   = 3'd6;
  localparam logic [2:0] REG_START_HIDDEN    = 3'd7;

  typedef struct packed {
    logic [7:0]  max_alpha;
    logic [7:0]  inactive_alpha;
    logic [15:0] fade_in_delay;
    logic [15:0] fade_out_delay;
    logic [15:0] idle_fade_delay;
    logic [15:0] fade_in_rate;
    logic [15:0] fade_out_rate;
    logic        start_hidden;
  } cfg_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;    // capture the input word
    logic step;    // evaluate one settle pass
    logic commit;  // publish the result word
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic changed;  // last pass moved the phase
  } dp_sts_t;
endpackage
`default_nettype wire

@@ rtl/oafc_datapath.sv @@
//------------------------------------------------------------------------------
// oafc_datapath: fade state and single-pass evaluation unit
// Holds phase, accumulator and alpha; one settle pass per step command.
//------------------------------------------------------------------------------
`default_nettype none
module oafc_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire oafc_pkg::cfg_t   cfg,
  input  wire oafc_pkg::dp_cmd_t cmd,
  output oafc_pkg::dp_sts_t     sts,
  input  wire logic             visible,
  input  wire logic             active,
  input  wire logic             disabled,
  input  wire logic [9:0]       frame_time,
  output logic [7:0]            alpha_out,
  output logic                  alpha_changed,
  output logic [3:0]            fade_phase
);
  import oafc_pkg::*;

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  logic [3:0]      phase, phase_next;
  logic [AccW-1:0] acc, acc_next;
  logic [7:0]      alpha_level;
  logic [7:0]      na, na_next;
  logic            vis, act, dis;
  // Step products are registered at load so no multiplier sits in the pass.
  logic [AccW-1:0] step_in, step_out, ms_ft;

  logic [25:0] prod_in, prod_out;
  assign prod_in  = 26'(cfg.fade_in_rate) * 26'(frame_time);
  assign prod_out = 26'(cfg.fade_out_rate) * 26'(frame_time);

  function automatic logic [AccW-1:0] scale_step(input logic [25:0] t);
    logic [26+FracBits:0] w;
    begin
      if (FracBits >= 8) w = (27'(t) << (FracBits - 8));
      else w = 27'(t) >> (8 - FracBits);
      scale_step = (|(w >> AccW)) ? {AccW{1'b1}} : w[AccW-1:0];
    end
  endfunction

  function automatic logic [AccW-1:0] sadd(input logic [AccW-1:0] a,
                                           input logic [AccW-1:0] b);
    logic [AccW:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sadd = s[AccW] ? AccMax : s[AccW-1:0];
    end
  endfunction

  function automatic logic [AccW-1:0] ssub(input logic [AccW-1:0] a,
                                           input logic [AccW-1:0] b);
    begin
      ssub = (b >= a) ? '0 : a - b;
    end
  endfunction

  function automatic logic [7:0] acc_alpha(input logic [AccW-1:0] a);
    logic [15:0] i;
    begin
      i = a[AccW-1:FracBits];
      acc_alpha = (i > 16'd255) ? 8'd255 : i[7:0];
    end
  endfunction

  function automatic logic [AccW-1:0] fx8(input logic [7:0] v);
    fx8 = AccW'(v) << FracBits;
  endfunction

  function automatic logic [AccW-1:0] fx16(input logic [15:0] v);
    fx16 = AccW'(v) << FracBits;
  endfunction

  logic hid, dim_ok;
  assign hid    = cfg.start_hidden && !act;
  assign dim_ok = cfg.inactive_alpha < cfg.max_alpha;

  always_comb begin
    logic [AccW-1:0] t;
    logic [7:0]      a;
    t = '0;
    a = '0;
    phase_next = phase;
    acc_next   = acc;
    na_next    = na;
    case (phase)
      PH_HIDDEN: begin
        na_next = '0;
        if (act && vis) begin
          phase_next = PH_MAX; acc_next = '0;
        end else if (vis && !hid) begin
          phase_next = PH_IN_DELAY; acc_next = '0;
        end
      end
      PH_IN_DELAY: begin
        if (act && vis) begin
          phase_next = PH_MAX; acc_next = '0;
        end else if (!vis) begin
          phase_next = PH_HIDDEN; acc_next = '0;
        end else begin
          t = sadd(acc, ms_ft);
          acc_next = t;
          if (t >= fx16(cfg.fade_in_delay)) begin
            phase_next = PH_FADING_IN; acc_next = '0;
          end
        end
      end
      PH_FADING_IN: begin
        t = sadd(acc, step_in);
        acc_next = t;
        a = acc_alpha(t);
        if (a > cfg.max_alpha) a = cfg.max_alpha;
        if (dis && dim_ok && a >= cfg.inactive_alpha) begin
          phase_next = PH_DIS_FADE;
          if (acc < fx8(cfg.inactive_alpha) && a > cfg.inactive_alpha)
            a = cfg.inactive_alpha;
        end else if (act || a >= cfg.max_alpha) begin
          phase_next = PH_MAX; acc_next = '0;
        end else if (!vis) begin
          phase_next = PH_FADING_OUT;
        end
        na_next = a;
      end
      PH_MAX: begin
        na_next = cfg.max_alpha;
        if (!vis) begin
          phase_next = PH_OUT_DELAY; acc_next = fx8(cfg.max_alpha);
        end else if (act) begin
          acc_next = '0;
        end else if (dis && dim_ok) begin
          phase_next = PH_DIS_FADE; acc_next = fx8(cfg.max_alpha);
        end else if (cfg.idle_fade_delay != '0 && dim_ok) begin
          t = sadd(acc, ms_ft);
          acc_next = t;
          if (t >= fx16(cfg.idle_fade_delay)) begin
            phase_next = PH_IDLE_FADE; acc_next = fx8(cfg.max_alpha);
          end
        end
      end
      PH_DIS_FADE, PH_IDLE_FADE: begin
        if (phase == PH_DIS_FADE && !dis && vis) begin
          phase_next = PH_FADING_IN;
          acc_next = fx8((cfg.inactive_alpha > na) ? cfg.inactive_alpha : na);
        end else if (!vis) begin
          phase_next = PH_FADING_OUT;
        end else begin
          t = ssub(acc, step_out);
          acc_next = t;
          a = acc_alpha(t);
          if (a < cfg.inactive_alpha) a = cfg.inactive_alpha;
          na_next = a;
          if (act) begin
            phase_next = PH_MAX; acc_next = '0;
          end else if (a <= cfg.inactive_alpha) begin
            phase_next = (phase == PH_IDLE_FADE) ? PH_INACTIVE : PH_DISABLED;
            acc_next = '0;
          end
        end
      end
      PH_DISABLED, PH_INACTIVE: begin
        if (phase == PH_DISABLED && !dis) begin
          phase_next = PH_FADING_IN; acc_next = fx8(cfg.inactive_alpha);
        end else if (phase == PH_DISABLED && cfg.idle_fade_delay != '0 && dim_ok
                     && sadd(acc, ms_ft) >= fx16(cfg.idle_fade_delay)) begin
          phase_next = PH_INACTIVE; acc_next = '0;
        end else begin
          if (phase == PH_DISABLED && cfg.idle_fade_delay != '0 && dim_ok)
            acc_next = sadd(acc, ms_ft);
          na_next = cfg.inactive_alpha;
          if (!vis) begin
            phase_next = PH_OUT_DELAY; acc_next = fx8(cfg.inactive_alpha);
          end else if (act) begin
            phase_next = PH_MAX; acc_next = '0;
          end
        end
      end
      PH_OUT_DELAY: begin
        if (vis) begin
          if (hid) begin
            phase_next = PH_HIDDEN; acc_next = '0;
          end else begin
            phase_next = PH_FADING_IN; acc_next = fx8(na);
          end
        end else begin
          t = sadd(acc, ms_ft);
          acc_next = t;
          if (t >= fx16(cfg.fade_out_delay)) begin
            phase_next = PH_FADING_OUT; acc_next = fx8(na);
          end
        end
      end
      PH_FADING_OUT: begin
        t = ssub(acc, step_out);
        acc_next = t;
        a = acc_alpha(t);
        na_next = a;
        if (a == '0) begin
          phase_next = PH_HIDDEN; acc_next = '0;
        end else if (vis) begin
          if (hid) begin
            phase_next = PH_HIDDEN; acc_next = '0;
          end else begin
            phase_next = PH_FADING_IN;
          end
        end
      end
      default: phase_next = PH_HIDDEN;
    endcase
  end

  assign sts.changed = (phase_next != phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HIDDEN;
      acc         <= '0;
      alpha_level <= '0;
      na          <= '0;
    end else begin
      if (cmd.load) begin
        na <= alpha_level;
      end
      if (cmd.step) begin
        phase <= phase_next;
        acc   <= acc_next;
        na    <= na_next;
      end
      if (cmd.commit) begin
        alpha_changed <= (na != alpha_level);
        alpha_level   <= na;
        alpha_out     <= na;
        fade_phase    <= phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vis      <= visible;
      act      <= active;
      dis      <= disabled;
      step_in  <= scale_step(prod_in);
      step_out <= scale_step(prod_out);
      ms_ft    <= AccW'(frame_time) << FracBits;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> alpha_out == alpha_level)
    else $error("published alpha differs from stored level");
  assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !cmd.load)
    else $error("step and load in the same cycle");
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> fade_phase <= PH_FADING_OUT)
    else $error("published phase out of range");
endmodule
`default_nettype wire

@@ rtl/oafc_ctrl.sv @@
//------------------------------------------------------------------------------
// oafc_ctrl: sequencer for the fade controller
// Loads a word, runs settle passes until stable or bounded, then publishes.
//------------------------------------------------------------------------------
`default_nettype none
module oafc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output oafc_pkg::dp_cmd_t      cmd,
  input  wire oafc_pkg::dp_sts_t sts
);
  import oafc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_PUB  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [PassW-1:0] pass, pass_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    pass_next  = pass;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          pass_next  = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step  = 1'b1;
        pass_next = pass + 1'b1;
        if (!sts.changed || pass_next == PassW'(MaxSettlePasses))
          state_next = S_PUB;
      end
      S_PUB: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> pass < PassW'(MaxSettlePasses))
    else $error("settle pass count exceeded bound");
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit not followed by valid result");
  assert property (@(posedge clk) disable iff (rst)
    $onehot({in_ready, state == S_RUN, state == S_PUB, out_valid}))
    else $error("controller state not one-hot");
endmodule
`default_nettype wire

@@ rtl/overlay_alpha_fade_controller.sv @@
//------------------------------------------------------------------------------
// overlay_alpha_fade_controller: per-frame alpha fade state machine
//
// Channel | Handshake                 | Payload
// in      | in_valid / in_ready       | visible, active, disabled, frame_time
// out     | out_valid / out_ready     | alpha_out, alpha_changed, fade_phase
// cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A word is loaded, runs 1 to 10 settle passes on the shared pass unit, and
// is then published, plus the output handshake.
// The settle loop (one evaluation per cycle) sets how long a word takes.
// Synchronous reset returns the phase to hidden and the registers to defaults.
// A stalled output holds the block; no new word is taken until it leaves.
//------------------------------------------------------------------------------
`default_nettype none
module overlay_alpha_fade_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        visible,
  input  wire logic        active,
  input  wire logic        disabled,
  input  wire logic [9:0]  frame_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       alpha_out,
  output logic             alpha_changed,
  output logic [3:0]       fade_phase,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import oafc_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_alpha       <= 8'd255;
      cfg.inactive_alpha  <= 8'd255;
      cfg.fade_in_delay   <= '0;
      cfg.fade_out_delay  <= '0;
      cfg.idle_fade_delay <= '0;
      cfg.fade_in_rate    <= 16'd256;
      cfg.fade_out_rate   <= 16'd256;
      cfg.start_hidden    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_ALPHA:       cfg.max_alpha       <= cfg_data[7:0];
        REG_INACTIVE_ALPHA:  cfg.inactive_alpha  <= cfg_data[7:0];
        REG_FADE_IN_DELAY:   cfg.fade_in_delay   <= cfg_data;
        REG_FADE_OUT_DELAY:  cfg.fade_out_delay  <= cfg_data;
        REG_IDLE_FADE_DELAY: cfg.idle_fade_delay <= cfg_data;
        REG_FADE_IN_RATE:    cfg.fade_in_rate    <= cfg_data;
        REG_FADE_OUT_RATE:   cfg.fade_out_rate   <= cfg_data;
        REG_START_HIDDEN:    cfg.start_hidden    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  oafc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  oafc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .visible       (visible),
    .active        (active),
    .disabled      (disabled),
    .frame_time    (frame_time),
    .alpha_out     (alpha_out),
    .alpha_changed (alpha_changed),
    .fade_phase    (fade_phase)
  );
endmodule
`default_nettype wire

@@ verif/overlay_alpha_fade_controller_test.sv @@
//------------------------------------------------------------------------------
// Overlay alpha fade controller testbench
// Drives frame ticks through the fade state machine under several register
// settings and random handshake pressure, and checks every result word
// against a cycle-free model of the per-tick settle loop.
//------------------------------------------------------------------------------
`default_nettype none
module overlay_alpha_fade_controller_test;
  import oafc_pkg::*;

  typedef struct packed {
    logic       visible;
    logic       active;
    logic       disabled;
    logic [9:0] frame_time;
  } tick_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic       changed;
    logic [3:0] phase;
  } fade_res_t;

  localparam logic [AccW-1:0] ACC_TOP = {AccW{1'b1}};

  class fade_scoreboard;
    cfg_t            regs;
    logic [3:0]      phase;
    logic [AccW-1:0] accum;
    logic [7:0]      level;
    fade_res_t       pending[$];
    int              errors;

    function new();
      errors = 0;
      regs = '{8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 16'd256, 16'd256, 1'b0};
      phase = PH_HIDDEN;
      accum = '0;
      level = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        REG_MAX_ALPHA:       regs.max_alpha = d[7:0];
        REG_INACTIVE_ALPHA:  regs.inactive_alpha = d[7:0];
        REG_FADE_IN_DELAY:   regs.fade_in_delay = d;
        REG_FADE_OUT_DELAY:  regs.fade_out_delay = d;
        REG_IDLE_FADE_DELAY: regs.idle_fade_delay = d;
        REG_FADE_IN_RATE:    regs.fade_in_rate = d;
        REG_FADE_OUT_RATE:   regs.fade_out_rate = d;
        REG_START_HIDDEN:    regs.start_hidden = d[0];
        default: ;
      endcase
    endfunction

    function logic [AccW-1:0] add_sat(logic [AccW-1:0] a, longint unsigned b);
      longint unsigned s;
      s = longint'(a) + b;
      return (s > longint'(ACC_TOP)) ? ACC_TOP : s[AccW-1:0];
    endfunction

    function logic [AccW-1:0] sub_sat(logic [AccW-1:0] a, longint unsigned b);
      return (b >= longint'(a)) ? '0 : AccW'(longint'(a) - b);
    endfunction

    function longint unsigned ms_fx(longint unsigned ms);
      return ms << FracBits;
    endfunction

    function longint unsigned step_of(logic [15:0] rate, logic [9:0] ms);
      longint unsigned t;
      t = longint'(rate) * longint'(ms);
      if (FracBits >= 8) return t << (FracBits - 8);
      return t >> (8 - FracBits);
    endfunction

    function logic [7:0] to_alpha(logic [AccW-1:0] a);
      longint unsigned v;
      v = longint'(a) >> FracBits;
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function logic [AccW-1:0] from_alpha(logic [7:0] a);
      return AccW'(longint'(a) << FracBits);
    endfunction

    // Runs one tick through the settle loop and queues its result word.
    function void note_tick(tick_t t);
      logic            hid, dim_ok;
      logic [7:0]      na;
      logic [3:0]      old;
      logic [AccW-1:0] prev;
      int              pass;
      fade_res_t       r;
      hid = regs.start_hidden && !t.active;
      dim_ok = regs.inactive_alpha < regs.max_alpha;
      na = level;
      pass = 0;
      do begin
        prev = accum;
        old = phase;
        case (phase)
          PH_HIDDEN: begin
            na = '0;
            if (t.active && t.visible) begin
              phase = PH_MAX; accum = '0;
            end else if (t.visible && !hid) begin
              phase = PH_IN_DELAY; accum = '0;
            end
          end
          PH_IN_DELAY: begin
            if (t.active && t.visible) begin
              phase = PH_MAX; accum = '0;
            end else if (!t.visible) begin
              phase = PH_HIDDEN; accum = '0;
            end else begin
              accum = add_sat(accum, ms_fx(t.frame_time));
              if (accum >= ms_fx(regs.fade_in_delay)) begin
                phase = PH_FADING_IN; accum = '0;
              end
            end
          end
          PH_FADING_IN: begin
            accum = add_sat(accum, step_of(regs.fade_in_rate, t.frame_time));
            na = to_alpha(accum);
            if (na > regs.max_alpha) na = regs.max_alpha;
            if (t.disabled && dim_ok && na >= regs.inactive_alpha) begin
              phase = PH_DIS_FADE;
              if (prev < from_alpha(regs.inactive_alpha) && na > regs.inactive_alpha)
                na = regs.inactive_alpha;
            end else if (t.active || na >= regs.max_alpha) begin
              phase = PH_MAX; accum = '0;
            end else if (!t.visible) phase = PH_FADING_OUT;
          end
          PH_MAX: begin
            na = regs.max_alpha;
            if (!t.visible) begin
              phase = PH_OUT_DELAY; accum = from_alpha(na);
            end else if (t.active) accum = '0;
            else if (t.disabled && dim_ok) begin
              phase = PH_DIS_FADE; accum = from_alpha(na);
            end else if (regs.idle_fade_delay > 0 && dim_ok) begin
              accum = add_sat(accum, ms_fx(t.frame_time));
              if (accum >= ms_fx(regs.idle_fade_delay)) begin
                phase = PH_IDLE_FADE; accum = from_alpha(na);
              end
            end
          end
          PH_DIS_FADE, PH_IDLE_FADE: begin
            if (phase == PH_DIS_FADE && !t.disabled && t.visible) begin
              phase = PH_FADING_IN;
              accum = from_alpha((regs.inactive_alpha > na) ? regs.inactive_alpha : na);
            end else if (!t.visible) phase = PH_FADING_OUT;
            else begin
              accum = sub_sat(accum, step_of(regs.fade_out_rate, t.frame_time));
              na = to_alpha(accum);
              if (na < regs.inactive_alpha) na = regs.inactive_alpha;
              if (t.active) begin
                phase = PH_MAX; accum = '0;
              end else if (na <= regs.inactive_alpha) begin
                phase = (old == PH_IDLE_FADE) ? PH_INACTIVE : PH_DISABLED;
                accum = '0;
              end
            end
          end
          PH_DISABLED, PH_INACTIVE: begin : dim_hold
            logic left;
            left = 1'b0;
            if (phase == PH_DISABLED) begin
              if (!t.disabled) begin
                phase = PH_FADING_IN; accum = from_alpha(regs.inactive_alpha);
                left = 1'b1;
              end else if (regs.idle_fade_delay > 0 && dim_ok) begin
                accum = add_sat(accum, ms_fx(t.frame_time));
                if (accum >= ms_fx(regs.idle_fade_delay)) begin
                  phase = PH_INACTIVE; accum = '0; left = 1'b1;
                end
              end
            end
            if (!left) begin
              na = regs.inactive_alpha;
              if (!t.visible) begin
                phase = PH_OUT_DELAY; accum = from_alpha(na);
              end else if (t.active) begin
                phase = PH_MAX; accum = '0;
              end
            end
          end
          PH_OUT_DELAY: begin
            if (t.visible) begin
              if (hid) begin
                phase = PH_HIDDEN; accum = '0;
              end else begin
                phase = PH_FADING_IN; accum = from_alpha(na);
              end
            end else begin
              accum = add_sat(accum, ms_fx(t.frame_time));
              if (accum >= ms_fx(regs.fade_out_delay)) begin
                phase = PH_FADING_OUT; accum = from_alpha(na);
              end
            end
          end
          PH_FADING_OUT: begin
            accum = sub_sat(accum, step_of(regs.fade_out_rate, t.frame_time));
            na = to_alpha(accum);
            if (na == 0) begin
              phase = PH_HIDDEN; accum = '0;
            end else if (t.visible) begin
              if (hid) begin
                phase = PH_HIDDEN; accum = '0;
              end else phase = PH_FADING_IN;
            end
          end
          default: phase = PH_HIDDEN;
        endcase
        pass++;
      end while (old != phase && pass < MaxSettlePasses);
      r.changed = (na != level);
      level = na;
      r.alpha = na;
      r.phase = phase;
      pending.push_back(r);
    endfunction

    function void check_word(fade_res_t got);
      fade_res_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: alpha %0d phase %0d",
               got.alpha, got.phase);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.alpha !== want.alpha) begin
        $error("alpha_out expected %0d actual %0d", want.alpha, got.alpha);
        errors++;
      end
      if (got.changed !== want.changed) begin
        $error("alpha_changed expected %0d actual %0d", want.changed, got.changed);
        errors++;
      end
      if (got.phase !== want.phase) begin
        $error("fade_phase expected %0d actual %0d", want.phase, got.phase);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_ready, visible, active, disabled;
  logic [9:0]  frame_time;
  logic        out_valid, out_ready, alpha_changed;
  logic [7:0]  alpha_out;
  logic [3:0]  fade_phase;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  fade_scoreboard sb;
  int send_idle_pct, recv_idle_pct, quiet_cycles;
  bit timed_out;

  overlay_alpha_fade_controller dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) sb.note_tick({visible, active, disabled, frame_time});
      if (out_valid && out_ready)
        sb.check_word('{alpha_out, alpha_changed, fade_phase});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) timed_out = 1'b1;
    end
  end

  // Valid stays high after an accept until the next word or the drain takes
  // over in the same time step, so no edge sees a stale word as new.
  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {visible, active, disabled, frame_time} <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && !timed_out) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_regs(cfg_t c);
    write_reg(REG_MAX_ALPHA, {8'd0, c.max_alpha});
    write_reg(REG_INACTIVE_ALPHA, {8'd0, c.inactive_alpha});
    write_reg(REG_FADE_IN_DELAY, c.fade_in_delay);
    write_reg(REG_FADE_OUT_DELAY, c.fade_out_delay);
    write_reg(REG_IDLE_FADE_DELAY, c.idle_fade_delay);
    write_reg(REG_FADE_IN_RATE, c.fade_in_rate);
    write_reg(REG_FADE_OUT_RATE, c.fade_out_rate);
    write_reg(REG_START_HIDDEN, {15'd0, c.start_hidden});
    cfg_valid <= 1'b0;
  endtask

  // Mostly plausible frames: steady visibility, short frame times.
  task automatic random_ticks(int n);
    tick_t t;
    logic  vis;
    vis = 1'b1;
    repeat (n) begin
      if ($urandom_range(9) == 0) vis = ~vis;
      t.visible = ($urandom_range(19) == 0) ? ~vis : vis;
      t.active = ($urandom_range(7) == 0);
      t.disabled = ($urandom_range(5) == 0);
      case ($urandom_range(9))
        0: t.frame_time = 10'($urandom_range(1023));
        1: t.frame_time = 10'd0;
        default: t.frame_time = 10'($urandom_range(40));
      endcase
      send_tick(t);
    end
  endtask

  cfg_t c;

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0; visible = 1'b0; active = 1'b0; disabled = 1'b0; frame_time = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    send_idle_pct = 20; recv_idle_pct = 84;
    quiet_cycles = 0; timed_out = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    fork
      begin
        // Directed frames at reset settings.
        send_tick('{1'b1, 1'b0, 1'b0, 10'd0});
        send_tick('{1'b1, 1'b0, 1'b0, 10'd16});
        send_tick('{1'b1, 1'b0, 1'b0, 10'd1023});
        send_tick('{1'b1, 1'b0, 1'b1, 10'd5});
        send_tick('{1'b1, 1'b0, 1'b0, 10'd5});
        send_tick('{1'b0, 1'b0, 1'b0, 10'd1});
        send_tick('{1'b0, 1'b0, 1'b0, 10'd1023});
        send_tick('{1'b1, 1'b1, 1'b0, 10'd3});
        drain();
        c = '{8'd200, 8'd60, 16'd20, 16'd30, 16'd50, 16'd384, 16'd1000, 1'b1};
        load_regs(c);
        send_tick('{1'b1, 1'b0, 1'b0, 10'd10});
        send_tick('{1'b1, 1'b1, 1'b0, 10'd10});
        send_tick('{1'b1, 1'b0, 1'b0, 10'd60});
        send_tick('{1'b1, 1'b0, 1'b1, 10'd2});
        send_tick('{1'b1, 1'b0, 1'b1, 10'd100});
        send_tick('{1'b1, 1'b0, 1'b0, 10'd1});
        send_tick('{1'b0, 1'b0, 1'b0, 10'd40});
        send_tick('{1'b1, 1'b0, 1'b0, 10'd1});
        send_tick('{1'b1, 1'b1, 1'b1, 10'd1023});
        drain();
        random_ticks(300);
        drain();
        send_idle_pct = 84; recv_idle_pct = 20;
        c = '{8'd0, 8'd255, 16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd0, 1'b0};
        load_regs(c);
        random_ticks(100);
        drain();
        c = '{8'd255, 8'd0, 16'd3, 16'd7, 16'd1, 16'd65535, 16'd65535, 1'b1};
        load_regs(c);
        random_ticks(250);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        c = '{8'd180, 8'd90, 16'd0, 16'd0, 16'd100, 16'd40, 16'd70, 1'b0};
        load_regs(c);
        random_ticks(250);
        drain();
        c = '{8'($urandom_range(255)), 8'($urandom_range(255)),
              16'($urandom_range(100)), 16'($urandom_range(100)),
              16'($urandom_range(200)), 16'($urandom_range(2000)),
              16'($urandom_range(2000)), 1'($urandom_range(1))};
        load_regs(c);
        random_ticks(180);
        drain();
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("FAIL overlay_alpha_fade_controller");
    end else if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS overlay_alpha_fade_controller");
    end else begin
      $display("FAIL overlay_alpha_fade_controller");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/oafc_pkg.sv
rtl/oafc_datapath.sv
rtl/oafc_ctrl.sv
rtl/overlay_alpha_fade_controller.sv
verif/overlay_alpha_fade_controller_test.sv
